FILE: sv/gradient_energy_conv2d_unit_macros.svh
// assertion macros shared by the gradient energy checker
`ifndef GRADIENT_ENERGY_CONV2D_UNIT_MACROS_SVH
`define GRADIENT_ENERGY_CONV2D_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define GEC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gradient energy check failed");

// next-cycle implication, off during reset
`define GEC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gradient energy check failed");

`endif

FILE: sv/gec_pkg.sv
// shared constants and types of the gradient energy filter
`default_nettype none
package gec_pkg;

  // default sizing
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_TAPS   = 15;
  localparam int DEF_COEFF_BITS = 16;

  // fixed field widths
  localparam int PIX_BITS     = 8;
  localparam int WIDTH_BITS   = 12;
  localparam int HEIGHT_BITS  = 11;
  localparam int HALF_BITS    = 3;
  localparam int CFG_BITS     = 12;
  localparam int CFG_IDX_BITS = 2;
  localparam int OP_BITS      = 2;
  localparam int CIDX_BITS    = 8;
  localparam int CVAL_BITS    = 16;
  localparam int ENERGY_BITS  = 63;
  localparam int CX_BITS      = 11;
  localparam int CY_BITS      = 10;

  // opcodes
  localparam logic [OP_BITS-1:0] OP_LOAD_X = 2'd0;
  localparam logic [OP_BITS-1:0] OP_LOAD_Y = 2'd1;
  localparam logic [OP_BITS-1:0] OP_PIXEL  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF   = 2'd2;

  // register reset values
  localparam logic [WIDTH_BITS-1:0]  RST_WIDTH  = 12'd1056;
  localparam logic [HEIGHT_BITS-1:0] RST_HEIGHT = 11'd704;
  localparam logic [HALF_BITS-1:0]   RST_HALF   = 3'd1;

  // energy saturation
  localparam logic [63:0] E_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ROOT_MAX = 64'd3037000499;

  // control word from the sequencer to the energy unit
  typedef struct packed {
    logic clear;
    logic tap_valid;
    logic last;
  } mac_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/gec_ram.sv
// generic single-write, registered-read ram
`default_nettype none
module gec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/gec_cell.sv
// one window column cell: holds a pixel column and passes it to its neighbor
`default_nettype none
module gec_cell import gec_pkg::*; #(
  parameter int TAPS = DEF_MAX_TAPS
) (
  input  logic                            clk,
  input  logic                            shift,
  input  logic [TAPS-1:0][PIX_BITS-1:0]   col_in,
  input  logic [$clog2(TAPS)-1:0]         row_sel,
  output logic [TAPS-1:0][PIX_BITS-1:0]   col_out,
  output logic [PIX_BITS-1:0]             tap
);

  logic [TAPS-1:0][PIX_BITS-1:0] col_q;

  // take the neighbor's column on a window shift
  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end
  end

  assign col_out = col_q;
  // pixel at the selected window row
  assign tap     = col_q[row_sel];

endmodule
`default_nettype wire

FILE: sv/gec_energy.sv
// multiply-accumulate of both kernels, then squares and saturated sum
`default_nettype none
module gec_energy import gec_pkg::*; #(
  parameter int MAX_TAPS   = DEF_MAX_TAPS,
  parameter int COEFF_BITS = DEF_COEFF_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mac_ctrl_t                    ctrl,
  input  logic [PIX_BITS-1:0]          tap,
  input  logic signed [COEFF_BITS-1:0] coef_x,
  input  logic signed [COEFF_BITS-1:0] coef_y,
  output logic                         done,
  output logic [ENERGY_BITS-1:0]       energy
);

  localparam int KSIZE     = MAX_TAPS * MAX_TAPS;
  localparam int PROD_BITS = COEFF_BITS + PIX_BITS + 1;
  localparam int ACC_BITS  = PROD_BITS + $clog2(KSIZE);

  logic signed [PROD_BITS-1:0] tap_ext, cx_ext, cy_ext;
  logic signed [PROD_BITS-1:0] prod_x, prod_y;
  logic signed [ACC_BITS-1:0]  acc_x, acc_y;
  logic [ACC_BITS-1:0]         mag_x, mag_y;
  logic                        v1, l1;
  logic [2:0]                  ph;
  logic [63:0]                 op64, sq_raw, sq_val, sq_x, sq_y, sum;
  logic [31:0]                 op_lo;

  assign tap_ext = PROD_BITS'({1'b0, tap});
  assign cx_ext  = PROD_BITS'(coef_x);
  assign cy_ext  = PROD_BITS'(coef_y);

  // product stage
  always_ff @(posedge clk) begin
    prod_x <= tap_ext * cx_ext;
    prod_y <= tap_ext * cy_ext;
  end

  // accumulate stage and square phase control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      l1   <= 1'b0;
      ph   <= 3'b000;
      done <= 1'b0;
    end else begin
      v1   <= ctrl.tap_valid;
      l1   <= ctrl.tap_valid & ctrl.last;
      ph   <= {ph[1:0], v1 & l1};
      done <= ph[2];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_x <= '0;
      acc_y <= '0;
    end else if (v1) begin
      acc_x <= acc_x + ACC_BITS'(prod_x);
      acc_y <= acc_y + ACC_BITS'(prod_y);
    end
  end

  // magnitudes
  assign mag_x = acc_x[ACC_BITS-1] ? ACC_BITS'(-acc_x) : ACC_BITS'(acc_x);
  assign mag_y = acc_y[ACC_BITS-1] ? ACC_BITS'(-acc_y) : ACC_BITS'(acc_y);

  // one shared squarer, x then y
  always_comb begin
    op64   = ph[0] ? 64'(mag_x) : 64'(mag_y);
    op_lo  = op64[31:0];
    sq_raw = op_lo * op_lo;
    sq_val = (op64 > ROOT_MAX) ? E_MAX : sq_raw;
    sum    = sq_x + sq_y;
  end

  always_ff @(posedge clk) begin
    if (ph[0]) begin
      sq_x <= sq_val;
    end
    if (ph[1]) begin
      sq_y <= sq_val;
    end
    if (ph[2]) begin
      energy <= (sum > E_MAX) ? E_MAX[ENERGY_BITS-1:0] : sum[ENERGY_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: sv/gradient_energy_conv2d_unit.sv
// top level of the gradient energy filter
// Usage: configure image_width, image_height and half_window through the
// write port (cfg_write, cfg_index, cfg_data) while the block is idle, load
// both kernels with opcode words (load x, load y), then stream pixel words in
// raster order on the input channel (in_valid / in_stall). Every pixel whose
// full window lies inside the image yields one result word on the output
// channel (out_valid / out_stall): energy, window center and frame_end.
// A border pixel reads the other MAX_TAPS - 1 rows of its column from the
// line store, one per cycle; an interior pixel then also runs side*side
// kernel taps, side = 2*half_window + 1, one per cycle from the kernel rams,
// plus the squaring tail. Coefficient and unused words leave the block idle.
// Reset clears the frame position, the registers to their defaults and the
// output channel; line store and kernels hold nothing defined until written.
// A stalled result stays in the output register; the next word is still
// taken, and the block waits only if a new result is ready before the old
// one has left.
`default_nettype none
module gradient_energy_conv2d_unit import gec_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_TAPS   = DEF_MAX_TAPS,
  parameter int COEFF_BITS = DEF_COEFF_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [OP_BITS-1:0]          opcode,
  input  logic [CIDX_BITS-1:0]        coeff_index,
  input  logic signed [CVAL_BITS-1:0] coeff_value,
  input  logic [PIX_BITS-1:0]         pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ENERGY_BITS-1:0]      energy,
  output logic [CX_BITS-1:0]          center_x,
  output logic [CY_BITS-1:0]          center_y,
  output logic                        frame_end,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [CFG_BITS-1:0]         cfg_data
);

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int RING_W   = $clog2(MAX_TAPS);
  localparam int KSIZE    = MAX_TAPS * MAX_TAPS;
  localparam int KA_W     = $clog2(KSIZE);
  localparam int LS_DEPTH = MAX_TAPS * (2 ** COL_W);
  localparam int LA_W     = $clog2(LS_DEPTH);
  localparam int HW_MAX   = (MAX_TAPS - 1) / 2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_LOADW = 6'b000100,
    S_SHIFT = 6'b001000,
    S_MAC   = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  state_t state;

  logic [WIDTH_BITS-1:0]  image_width, w_eff;
  logic [HEIGHT_BITS-1:0] image_height, h_eff;
  logic [HALF_BITS-1:0]   half_window, hw_eff;

  logic [COL_W-1:0]  col, cur_col;
  logic [ROW_W-1:0]  row;
  logic [RING_W-1:0] ring, rd_ring, ld_slot, rd_slot, base_q, span_q, fx, fy;
  logic [RING_W-1:0] row_sel, col_sel;
  logic [KA_W-1:0]   kaddr;
  logic              rd_v, emit_q, emit_now, col_wrap, row_wrap, frame_last;
  logic [CX_BITS-1:0] cx_q;
  logic [CY_BITS-1:0] cy_q;
  logic               fe_q;

  logic accept, is_pix, is_coef, idx_ok, shift_en, out_load, e_done, e_ready;
  logic [PIX_BITS-1:0] ls_rdata, window_tap, tap_q;
  logic [COEFF_BITS-1:0] coeff_wrap, kx_rdata, ky_rdata;
  logic [ENERGY_BITS-1:0] e_energy;
  mac_ctrl_t ctrl_q;

  logic [MAX_TAPS-1:0][PIX_BITS-1:0]                load_buf;
  logic [MAX_TAPS-1:0][MAX_TAPS-1:0][PIX_BITS-1:0]  chain;
  logic [MAX_TAPS-1:0][PIX_BITS-1:0]                cell_tap;

  // handshake decode
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_pix   = (opcode == OP_PIXEL);
  assign is_coef  = (opcode == OP_LOAD_X) || (opcode == OP_LOAD_Y);
  assign idx_ok   = int'(coeff_index) < KSIZE;
  assign coeff_wrap = COEFF_BITS'(coeff_value);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_WIDTH;
      image_height <= RST_HEIGHT;
      half_window  <= RST_HALF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data[HEIGHT_BITS-1:0];
        REG_HALF:   half_window  <= cfg_data[HALF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  always_comb begin
    w_eff = image_width;
    if (image_width == '0) begin
      w_eff = WIDTH_BITS'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = WIDTH_BITS'(MAX_WIDTH);
    end
    h_eff = image_height;
    if (image_height == '0) begin
      h_eff = HEIGHT_BITS'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      h_eff = HEIGHT_BITS'(MAX_HEIGHT);
    end
    hw_eff = half_window;
    if (2 * int'(half_window) + 1 > MAX_TAPS) begin
      hw_eff = HALF_BITS'(HW_MAX);
    end
  end

  // window and wrap tests at the current position
  assign emit_now   = (int'(col) >= 2 * int'(hw_eff)) && (int'(row) >= 2 * int'(hw_eff)) &&
                      (int'(col) < int'(w_eff)) && (int'(row) < int'(h_eff));
  assign col_wrap   = int'(col) + 1 >= int'(w_eff);
  assign row_wrap   = int'(row) + 1 >= int'(h_eff);
  assign frame_last = (int'(col) == int'(w_eff) - 1) && (int'(row) == int'(h_eff) - 1);

  // frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      ring <= '0;
    end else if (accept && is_coef) begin
      col  <= '0;
      row  <= '0;
      ring <= '0;
    end else if (accept && is_pix) begin
      if (col_wrap) begin
        col <= '0;
        if (row_wrap) begin
          row  <= '0;
          ring <= '0;
        end else begin
          row  <= row + 1'b1;
          ring <= (int'(ring) == MAX_TAPS - 1) ? '0 : ring + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // per-pixel item data
  always_ff @(posedge clk) begin
    if (accept && is_pix) begin
      cur_col <= col;
      cx_q    <= CX_BITS'(int'(col) - int'(hw_eff));
      cy_q    <= CY_BITS'(int'(row) - int'(hw_eff));
      fe_q    <= frame_last;
      base_q  <= RING_W'(MAX_TAPS - 1 - 2 * int'(hw_eff));
      span_q  <= RING_W'(2 * int'(hw_eff));
      load_buf[MAX_TAPS-1] <= pixel;
    end
    if (rd_v) begin
      load_buf[rd_slot] <= ls_rdata;
    end
  end

  // line store, one row of the ring per image row
  gec_ram #(.WIDTH(PIX_BITS), .DEPTH(LS_DEPTH)) u_line_store (
    .clk   (clk),
    .we    (accept && is_pix),
    .waddr (LA_W'({ring, col})),
    .wdata (pixel),
    .raddr (LA_W'({rd_ring, cur_col})),
    .rdata (ls_rdata)
  );

  // kernel stores
  gec_ram #(.WIDTH(COEFF_BITS), .DEPTH(KSIZE)) u_kx_store (
    .clk   (clk),
    .we    (accept && (opcode == OP_LOAD_X) && idx_ok),
    .waddr (KA_W'(coeff_index)),
    .wdata (coeff_wrap),
    .raddr (kaddr),
    .rdata (kx_rdata)
  );

  gec_ram #(.WIDTH(COEFF_BITS), .DEPTH(KSIZE)) u_ky_store (
    .clk   (clk),
    .we    (accept && (opcode == OP_LOAD_Y) && idx_ok),
    .waddr (KA_W'(coeff_index)),
    .wdata (coeff_wrap),
    .raddr (kaddr),
    .rdata (ky_rdata)
  );

  // window: chain of column cells, newest column at the top end
  assign shift_en = (state == S_SHIFT);
  assign row_sel  = base_q + fy;
  assign col_sel  = base_q + fx;

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    logic [MAX_TAPS-1:0][PIX_BITS-1:0] col_in;
    if (j == MAX_TAPS - 1) begin : g_head
      assign col_in = load_buf;
    end else begin : g_body
      assign col_in = chain[j+1];
    end
    gec_cell #(.TAPS(MAX_TAPS)) u_cell (
      .clk     (clk),
      .shift   (shift_en),
      .col_in  (col_in),
      .row_sel (row_sel),
      .col_out (chain[j]),
      .tap     (cell_tap[j])
    );
  end

  assign window_tap = cell_tap[col_sel];

  // tap aligned with the kernel read data
  always_ff @(posedge clk) begin
    tap_q <= window_tap;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ld_slot <= '0;
      rd_slot <= '0;
      rd_ring <= '0;
      rd_v    <= 1'b0;
      emit_q  <= 1'b0;
      fx      <= '0;
      fy      <= '0;
      kaddr   <= '0;
      ctrl_q  <= '0;
    end else begin
      rd_v    <= (state == S_LOAD);
      rd_slot <= ld_slot;
      ctrl_q.clear     <= (state == S_SHIFT) && emit_q;
      ctrl_q.tap_valid <= (state == S_MAC);
      ctrl_q.last      <= (state == S_MAC) && (fx == span_q) && (fy == span_q);
      unique case (state)
        S_IDLE: begin
          if (accept && is_pix) begin
            state   <= S_LOAD;
            ld_slot <= '0;
            rd_ring <= (int'(ring) == MAX_TAPS - 1) ? '0 : ring + 1'b1;
            emit_q  <= emit_now;
          end
        end
        S_LOAD: begin
          ld_slot <= ld_slot + 1'b1;
          rd_ring <= (int'(rd_ring) == MAX_TAPS - 1) ? '0 : rd_ring + 1'b1;
          if (int'(ld_slot) == MAX_TAPS - 2) begin
            state <= S_LOADW;
          end
        end
        S_LOADW: begin
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          fx    <= '0;
          fy    <= '0;
          kaddr <= '0;
          state <= emit_q ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          kaddr <= kaddr + 1'b1;
          if (fx == span_q) begin
            fx <= '0;
            fy <= fy + 1'b1;
            if (fy == span_q) begin
              state <= S_WAIT;
            end
          end else begin
            fx <= fx + 1'b1;
          end
        end
        S_WAIT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // squared gradient energy
  gec_energy #(.MAX_TAPS(MAX_TAPS), .COEFF_BITS(COEFF_BITS)) u_energy (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl_q),
    .tap    (tap_q),
    .coef_x (kx_rdata),
    .coef_y (ky_rdata),
    .done   (e_done),
    .energy (e_energy)
  );

  // output register
  assign out_load = (state == S_WAIT) && (e_done || e_ready) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_ready   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        e_ready <= 1'b0;
      end else if (e_done) begin
        e_ready <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      energy    <= e_energy;
      center_x  <= cx_q;
      center_y  <= cy_q;
      frame_end <= fe_q;
    end
  end

endmodule
`default_nettype wire

FILE: sv/gec_checker.sv
// port-level checks of the gradient energy filter and their binding
`default_nettype none
`include "gradient_energy_conv2d_unit_macros.svh"
module gec_checker import gec_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic [OP_BITS-1:0]     opcode,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [ENERGY_BITS-1:0] energy
);

  // a stalled result word holds
  `GEC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(energy))

  // a taken pixel word always makes the block busy
  `GEC_ASSERT_NEXT(a_pix_busy, clk, rst, in_valid && !in_stall && (opcode == OP_PIXEL), in_stall)

  // a new result only comes out of a busy pixel
  `GEC_ASSERT_NOW(a_out_from_busy, clk, rst, $rose(out_valid), $past(in_stall))

  // output channel empty right after reset
  `GEC_ASSERT_NOW(a_rst_empty, clk, rst, $past(rst), !out_valid)

endmodule

bind gradient_energy_conv2d_unit gec_checker u_gec_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .opcode    (opcode),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .energy    (energy)
);
`default_nettype wire

FILE: tb/sv/gradient_energy_conv2d_unit_test.sv
// self-checking testbench of the gradient energy filter: directed words, then random frames
`default_nettype none
module gradient_energy_conv2d_unit_test;
  import gec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_ROWS   = DEF_MAX_TAPS;
  localparam int LINE_COLS   = DEF_MAX_WIDTH;
  localparam int KERNEL_SIZE = DEF_MAX_TAPS * DEF_MAX_TAPS;
  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE      = 300;
  localparam int ITEMS       = 1150;
  localparam logic [OP_BITS-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [ENERGY_BITS-1:0] energy;
    logic [CX_BITS-1:0]     cx;
    logic [CY_BITS-1:0]     cy;
    logic                   fe;
  } grad_result_t;

  typedef struct packed {
    logic [OP_BITS-1:0]          op;
    logic [CIDX_BITS-1:0]        idx;
    logic signed [CVAL_BITS-1:0] val;
    logic [PIX_BITS-1:0]         pix;
    bit                          typed;
    grad_result_t                res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_BITS-1:0] opcode = OP_PIXEL;
  logic [CIDX_BITS-1:0] coeff_index = '0;
  logic signed [CVAL_BITS-1:0] coeff_value = '0;
  logic [PIX_BITS-1:0] pixel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ENERGY_BITS-1:0] energy;
  logic [CX_BITS-1:0] center_x;
  logic [CY_BITS-1:0] center_y;
  logic frame_end;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  gradient_energy_conv2d_unit dut (
    .clk, .rst, .in_valid, .in_stall, .opcode, .coeff_index, .coeff_value, .pixel,
    .out_valid, .out_stall, .energy, .center_x, .center_y, .frame_end,
    .cfg_write, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // filter state as seen from outside
  logic [PIX_BITS-1:0] line_mem [LINE_ROWS][LINE_COLS];
  int x_taps [KERNEL_SIZE];
  int y_taps [KERNEL_SIZE];
  int pos_col, pos_row;
  int reg_width = RST_WIDTH, reg_height = RST_HEIGHT, reg_half = RST_HALF;

  grad_result_t pending_results[$];
  stim_row_t stim_rows[$];
  int fails;
  bit calm;
  int hold_reqs;
  int holds_done;
  int idle_cycles;
  int words_sent;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fails++;
  endtask

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // compute the energy word a filter word causes, updating the state
  task automatic filter_word(input stim_row_t w, output bit emit, output grad_result_t r);
    int wd, ht, side, col, row, k;
    longint dx, dy, p;
    longint unsigned e;
    emit = 0;
    r = '0;
    if (w.op == OP_LOAD_X || w.op == OP_LOAD_Y) begin
      if (w.idx < KERNEL_SIZE) begin
        if (w.op == OP_LOAD_X) x_taps[w.idx] = int'($signed(w.val));
        else y_taps[w.idx] = int'($signed(w.val));
      end
      pos_col = 0;
      pos_row = 0;
      return;
    end
    if (w.op != OP_PIXEL) return;
    wd = (reg_width == 0) ? 1 : (reg_width > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : reg_width);
    ht = (reg_height == 0) ? 1 : (reg_height > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : reg_height);
    side = 2 * reg_half + 1;
    col = pos_col;
    row = pos_row;
    line_mem[row % LINE_ROWS][col] = w.pix;
    emit = col >= 2 * reg_half && row >= 2 * reg_half && col < wd && row < ht;
    if (emit) begin
      dx = 0;
      dy = 0;
      for (int fy = 0; fy < side; fy++)
        for (int fx = 0; fx < side; fx++) begin
          p = line_mem[(row - 2 * reg_half + fy) % LINE_ROWS][col - 2 * reg_half + fx];
          k = fx + fy * side;
          dx += p * x_taps[k];
          dy += p * y_taps[k];
        end
      e = dx * dx + dy * dy;
      r.energy = e[ENERGY_BITS-1:0];
      r.cx = CX_BITS'(col - reg_half);
      r.cy = CY_BITS'(row - reg_half);
      r.fe = (col == wd - 1 && row == ht - 1);
    end
    col++;
    if (col >= wd) begin
      col = 0;
      row++;
      if (row >= ht) row = 0;
    end
    pos_col = col;
    pos_row = row;
  endtask

  // offer one word after a random gap, hold it until taken
  task automatic send_word(input stim_row_t w);
    bit emit;
    grad_result_t r;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    opcode <= w.op;
    coeff_index <= w.idx;
    coeff_value <= w.val;
    pixel <= w.pix;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    filter_word(w, emit, r);
    if (w.typed) pending_results = {pending_results, w.res};
    else if (emit) pending_results = {pending_results, r};
  endtask

  function automatic stim_row_t make_word(input logic [OP_BITS-1:0] op,
                                          input int idx, input int val, input int pix);
    stim_row_t w;
    w = '0;
    w.op = op;
    w.idx = CIDX_BITS'(idx);
    w.val = CVAL_BITS'(val);
    w.pix = PIX_BITS'(pix);
    return w;
  endfunction

  // let the block drain, then write one register
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_BITS'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_WIDTH:  reg_width = value;
      REG_HEIGHT: reg_height = value;
      REG_HALF:   reg_half = value;
      default: ;
    endcase
  endtask

  function automatic int rand_coeff();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    return $signed(16'($urandom()));
  endfunction

  function automatic int rand_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 255;
    return $urandom_range(0, 255);
  endfunction

  // one frame setting: registers, both kernels, then a pixel stream
  task automatic run_frame(input int wd, input int ht, input int half, input int npix);
    int side;
    calm = ($urandom_range(0, 3) == 0);
    write_reg(REG_WIDTH, wd);
    write_reg(REG_HEIGHT, ht);
    write_reg(REG_HALF, half);
    side = 2 * half + 1;
    for (int k = 0; k < side * side; k++) begin
      send_word(make_word(OP_LOAD_X, k, rand_coeff(), 0));
      send_word(make_word(OP_LOAD_Y, k, rand_coeff(), 0));
    end
    for (int n = 0; n < npix; n++) begin
      // occasional ignored word in the stream
      if ($urandom_range(0, 49) == 0)
        send_word(make_word(OP_UNUSED, $urandom_range(0, 255), rand_coeff(), rand_pixel()));
      // one long receiver hold-off while the stream keeps coming
      if (n == 20 && half == 0) hold_reqs++;
      send_word(make_word(OP_PIXEL, 0, 0, rand_pixel()));
    end
  endtask

  // receiver stall: random gaps plus a long counted hold-off on request
  int rx_left;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_left <= 0;
    end else if (holds_done != hold_reqs) begin
      holds_done <= hold_reqs;
      rx_left <= 400;
      out_stall <= 1'b1;
    end else if (rx_left > 0) begin
      rx_left <= rx_left - 1;
      out_stall <= 1'b1;
    end else begin
      rx_left <= pick_gap();
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    grad_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (energy !== want.energy)
          report($sformatf("energy %0d, expected %0d", energy, want.energy));
        if (center_x !== want.cx)
          report($sformatf("center_x %0d, expected %0d", center_x, want.cx));
        if (center_y !== want.cy)
          report($sformatf("center_y %0d, expected %0d", center_y, want.cy));
        if (frame_end !== want.fe)
          report($sformatf("frame_end %0b, expected %0b", frame_end, want.fe));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("gradient_energy_conv2d_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // directed rows on a 3x2 frame with a 1x1 kernel
  task automatic add_row(input logic [OP_BITS-1:0] op, input int idx, input int val,
                         input int pix, input bit typed, input longint unsigned e,
                         input int cx, input int cy, input bit fe);
    stim_row_t w;
    w = make_word(op, idx, val, pix);
    w.typed = typed;
    w.res.energy = e[ENERGY_BITS-1:0];
    w.res.cx = CX_BITS'(cx);
    w.res.cy = CY_BITS'(cy);
    w.res.fe = fe;
    stim_rows = {stim_rows, w};
  endtask

  initial begin
    int wd, ht, half;
    longint unsigned both_sq;
    both_sq = 64'd1073741824 + 64'd1073676289;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 2);
    write_reg(REG_HALF, 0);
    write_reg(REG_UNUSED, 12'hFFF);
    add_row(OP_LOAD_X, 0, -32768, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD_Y, 0, 32767, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD_X, 255, 16'h1234, 0, 0, 0, 0, 0, 0);
    add_row(OP_LOAD_Y, 225, 16'h5A5A, 0, 0, 0, 0, 0, 0);
    add_row(OP_UNUSED, 0, 0, 255, 0, 0, 0, 0, 0);
    add_row(OP_PIXEL, 0, 0, 255, 1, 64'd65025 * both_sq, 0, 0, 0);
    add_row(OP_PIXEL, 0, 0, 0, 1, 0, 1, 0, 0);
    add_row(OP_UNUSED, 255, -1, 0, 0, 0, 0, 0, 0);
    add_row(OP_PIXEL, 0, 0, 1, 1, both_sq, 2, 0, 0);
    add_row(OP_PIXEL, 0, 0, 128, 0, 0, 0, 0, 0);
    add_row(OP_PIXEL, 0, 0, 255, 0, 0, 0, 0, 0);
    add_row(OP_PIXEL, 0, 0, 7, 0, 0, 0, 0, 0);
    add_row(OP_PIXEL, 0, 0, 170, 0, 0, 0, 0, 0);
    add_row(OP_PIXEL, 0, 0, 85, 0, 0, 0, 0, 0);
    foreach (stim_rows[i]) send_word(stim_rows[i]);

    // extremes of the registers
    run_frame(4095, 0, 0, 40);
    run_frame(0, 2047, 0, 30);
    run_frame(15, 15, 7, 225);
    run_frame(16, 1024, 1, 48);
    run_frame(1, 1, 0, 5);

    // random frame settings, mostly small
    while (words_sent < ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        half = 4;
        wd = $urandom_range(9, 11);
        ht = $urandom_range(9, 10);
      end else begin
        half = $urandom_range(0, 3);
        wd = $urandom_range(1, 12);
        ht = $urandom_range(1, 8);
      end
      run_frame(wd, ht, half, wd * ht + $urandom_range(0, wd));
      // sender waits for the block to drain now and then
      if ($urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
      end
    end

    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (fails == 0)
      $display("gradient_energy_conv2d_unit test passed");
    else
      $display("gradient_energy_conv2d_unit test failed");
    $finish;
  end

endmodule
`default_nettype wire
